>>> rtl/core/element_region_tagger_defines.svh
// Assertion macros for the element region tagger checker.
// Needs clk and rst_n in scope at the point of use.
`ifndef ELEMENT_REGION_TAGGER_DEFINES_SVH
`define ELEMENT_REGION_TAGGER_DEFINES_SVH

// same-cycle implication
`define ERT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ERT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/ert_pkg.sv
// Shared types and constants of the element region tagger.
// No dependencies.
`timescale 1ns / 1ps

package ert_pkg;

  localparam int FIELD_W = 32;
  localparam int TAG_W   = 32;

  localparam logic [TAG_W-1:0] TAG_OUTSIDE = TAG_W'(1);
  localparam logic [TAG_W-1:0] TAG_FIRST   = TAG_W'(2);
  localparam logic [TAG_W-1:0] TAG_MAX     = {TAG_W{1'b1}};

  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_APPEND   = 2'd1,
    OP_CLASSIFY = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

endpackage

>>> rtl/core/ert_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ert_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_r <= mem[raddr_i];
  end

  assign rdata_o = rdata_r;

endmodule

>>> rtl/core/ert_edge_pipe.sv
// Segment crossing pipeline: differences, six products, three cross terms, strict test.
// Depends on nothing but its ports; one segment may enter per cycle.
`timescale 1ns / 1ps

module ert_edge_pipe #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          seg_vld_i,
  input  logic [COORD_WIDTH-1:0]        p_x_i,
  input  logic [COORD_WIDTH-1:0]        p_y_i,
  input  logic [COORD_WIDTH-1:0]        p2_x_i,
  input  logic [COORD_WIDTH-1:0]        p2_y_i,
  input  logic [COORD_WIDTH-1:0]        q_x_i,
  input  logic [COORD_WIDTH-1:0]        q_y_i,
  input  logic signed [COORD_WIDTH+1:0] s_x_i,
  input  logic signed [COORD_WIDTH+1:0] s_y_i,
  output logic                          hit_vld_o,
  output logic                          hit_o,
  output logic                          busy_o
);

  localparam int W  = COORD_WIDTH;
  localparam int DW = W + 1;
  localparam int PW = 2 * W + 3;
  localparam int XW = 2 * W + 4;

  logic                 a_vld_r;
  logic signed [DW-1:0] a_rx_r, a_ry_r, a_wx_r, a_wy_r;
  logic signed [DW-1:0] a_rx_nxt, a_ry_nxt, a_wx_nxt, a_wy_nxt;

  logic                 b_vld_r;
  logic signed [PW-1:0] b_rs1_r, b_rs2_r, b_ws1_r, b_ws2_r, b_wr1_r, b_wr2_r;
  logic signed [PW-1:0] b_rs1_nxt, b_rs2_nxt, b_ws1_nxt, b_ws2_nxt, b_wr1_nxt, b_wr2_nxt;

  logic                 c_vld_r;
  logic signed [XW-1:0] c_den_r, c_t_r, c_u_r;
  logic signed [XW-1:0] c_den_nxt, c_t_nxt, c_u_nxt;

  logic den_nz, den_pos, t_in, u_in;

  // stage A: segment direction and offset to centroid
  always_comb begin
    a_rx_nxt = {p2_x_i[W-1], p2_x_i} - {p_x_i[W-1], p_x_i};
    a_ry_nxt = {p2_y_i[W-1], p2_y_i} - {p_y_i[W-1], p_y_i};
    a_wx_nxt = {q_x_i[W-1], q_x_i} - {p_x_i[W-1], p_x_i};
    a_wy_nxt = {q_y_i[W-1], q_y_i} - {p_y_i[W-1], p_y_i};
  end

  // stage B: products
  always_comb begin
    b_rs1_nxt = a_rx_r * s_y_i;
    b_rs2_nxt = a_ry_r * s_x_i;
    b_ws1_nxt = a_wx_r * s_y_i;
    b_ws2_nxt = a_wy_r * s_x_i;
    b_wr1_nxt = a_wx_r * a_ry_r;
    b_wr2_nxt = a_wy_r * a_rx_r;
  end

  // stage C: cross terms
  always_comb begin
    c_den_nxt = {b_rs1_r[PW-1], b_rs1_r} - {b_rs2_r[PW-1], b_rs2_r};
    c_t_nxt   = {b_ws1_r[PW-1], b_ws1_r} - {b_ws2_r[PW-1], b_ws2_r};
    c_u_nxt   = {b_wr1_r[PW-1], b_wr1_r} - {b_wr2_r[PW-1], b_wr2_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      a_vld_r <= seg_vld_i;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_rx_r  <= a_rx_nxt;
    a_ry_r  <= a_ry_nxt;
    a_wx_r  <= a_wx_nxt;
    a_wy_r  <= a_wy_nxt;
    b_rs1_r <= b_rs1_nxt;
    b_rs2_r <= b_rs2_nxt;
    b_ws1_r <= b_ws1_nxt;
    b_ws2_r <= b_ws2_nxt;
    b_wr1_r <= b_wr1_nxt;
    b_wr2_r <= b_wr2_nxt;
    c_den_r <= c_den_nxt;
    c_t_r   <= c_t_nxt;
    c_u_r   <= c_u_nxt;
  end

  // strict crossing: both parameters strictly between zero and the denominator
  always_comb begin
    den_nz  = (c_den_r != '0);
    den_pos = !c_den_r[XW-1];
    if (den_pos) begin
      t_in = !c_t_r[XW-1] && (c_t_r != '0) && (c_t_r < c_den_r);
      u_in = !c_u_r[XW-1] && (c_u_r != '0) && (c_u_r < c_den_r);
    end else begin
      t_in = c_t_r[XW-1] && (c_t_r > c_den_r);
      u_in = c_u_r[XW-1] && (c_u_r > c_den_r);
    end
  end

  assign hit_vld_o = c_vld_r;
  assign hit_o     = den_nz && t_in && u_in;
  assign busy_o    = a_vld_r || b_vld_r || c_vld_r;

endmodule

>>> rtl/core/element_region_tagger.sv
// Append and clear finish at the accepting edge and never raise busy.
// Classify: ST_RUN reads the vertices in order and the edge pipe tests each edge;
// ST_DRAIN then sends the result; the next word is taken once busy drops.
// Throughput is set by the vertex RAM read port: one polygon vertex per cycle.
// Reset: synchronous on rst_n low; empties the polygon, restarts tags at 2.
// Results are strobed on out_valid for one cycle; the receiver cannot stall.
`timescale 1ns / 1ps

module element_region_tagger #(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_WIDTH  = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_op,
  input  logic [ert_pkg::FIELD_W-1:0] in_ax,
  input  logic [ert_pkg::FIELD_W-1:0] in_ay,
  input  logic [ert_pkg::FIELD_W-1:0] in_bx,
  input  logic [ert_pkg::FIELD_W-1:0] in_by_coord,
  input  logic [ert_pkg::FIELD_W-1:0] in_cx,
  input  logic [ert_pkg::FIELD_W-1:0] in_cy,
  input  logic [ert_pkg::FIELD_W-1:0] in_dx_coord,
  input  logic [ert_pkg::FIELD_W-1:0] in_dy_coord,
  output logic                        out_valid,
  output logic                        out_inside_res,
  output logic [ert_pkg::TAG_W-1:0]   out_tag
);

  localparam int W     = COORD_WIDTH;
  localparam int SW    = W + 2;
  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  localparam logic [W-1:0] COORD_MIN = {1'b1, {(W-1){1'b0}}};

  ert_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [W-1:0]              max_x_r, max_x_nxt, max_y_r, max_y_nxt;
  logic [ert_pkg::TAG_W-1:0] next_tag_r, next_tag_nxt;
  logic [IDX_W-1:0]          rd_idx_r, rd_idx_nxt;
  logic                      rv_r, rv_nxt, rv_first_r, rv_first_nxt, rv_last_r, rv_last_nxt;
  logic                      close_pend_r, close_pend_nxt;
  logic                      parity_r, parity_nxt;
  logic                      out_valid_r, out_valid_nxt, out_inside_r, out_inside_nxt;
  logic [ert_pkg::TAG_W-1:0] out_tag_r, out_tag_nxt;

  logic [W-1:0]          q_x_r, q_y_r, first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic signed [SW-1:0]  s_x_r, s_y_r;

  logic                  accept, app_ok, rd_last, pipe_empty;
  logic [W-1:0]          ax_w, ay_w, bx_w, by_w, cx_w, cy_w, dx_w, dy_w;
  logic [W+1:0]          sum_x, sum_y;
  logic [2*W-1:0]        ram_rdata;
  logic [W-1:0]          rd_x, rd_y, seg_p2_x, seg_p2_y;
  logic                  seg_vld, hit_vld, hit, pipe_busy;

  assign busy   = (state_r != ert_pkg::ST_IDLE);
  assign accept = start && !busy;

  assign ax_w = in_ax[W-1:0];
  assign ay_w = in_ay[W-1:0];
  assign bx_w = in_bx[W-1:0];
  assign by_w = in_by_coord[W-1:0];
  assign cx_w = in_cx[W-1:0];
  assign cy_w = in_cy[W-1:0];
  assign dx_w = in_dx_coord[W-1:0];
  assign dy_w = in_dy_coord[W-1:0];

  assign sum_x = {{2{ax_w[W-1]}}, ax_w} + {{2{bx_w[W-1]}}, bx_w}
               + {{2{cx_w[W-1]}}, cx_w} + {{2{dx_w[W-1]}}, dx_w};
  assign sum_y = {{2{ay_w[W-1]}}, ay_w} + {{2{by_w[W-1]}}, by_w}
               + {{2{cy_w[W-1]}}, cy_w} + {{2{dy_w[W-1]}}, dy_w};

  assign app_ok  = accept && (in_op == ert_pkg::OP_APPEND) &&
                   (count_r < CNT_W'(MAX_VERTICES));
  assign rd_last = (CNT_W'(rd_idx_r) + CNT_W'(1)) == count_r;

  ert_ram #(
    .WIDTH (2 * W),
    .DEPTH (MAX_VERTICES)
  ) u_vert_ram (
    .clk     (clk),
    .we_i    (app_ok),
    .waddr_i (count_r[IDX_W-1:0]),
    .wdata_i ({ay_w, ax_w}),
    .raddr_i (rd_idx_r),
    .rdata_o (ram_rdata)
  );

  assign rd_x = ram_rdata[W-1:0];
  assign rd_y = ram_rdata[2*W-1:W];

  // stored edge while streaming, closing edge after the last vertex
  assign seg_vld  = (rv_r && !rv_first_r) || close_pend_r;
  assign seg_p2_x = rv_r ? rd_x : first_x_r;
  assign seg_p2_y = rv_r ? rd_y : first_y_r;

  ert_edge_pipe #(
    .COORD_WIDTH (W)
  ) u_edge_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .seg_vld_i (seg_vld),
    .p_x_i     (prev_x_r),
    .p_y_i     (prev_y_r),
    .p2_x_i    (seg_p2_x),
    .p2_y_i    (seg_p2_y),
    .q_x_i     (q_x_r),
    .q_y_i     (q_y_r),
    .s_x_i     (s_x_r),
    .s_y_i     (s_y_r),
    .hit_vld_o (hit_vld),
    .hit_o     (hit),
    .busy_o    (pipe_busy)
  );

  assign pipe_empty = !rv_r && !close_pend_r && !pipe_busy;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    max_x_nxt      = max_x_r;
    max_y_nxt      = max_y_r;
    next_tag_nxt   = next_tag_r;
    rd_idx_nxt     = rd_idx_r;
    rv_nxt         = 1'b0;
    rv_first_nxt   = rv_first_r;
    rv_last_nxt    = rv_last_r;
    close_pend_nxt = rv_r && rv_last_r;
    parity_nxt     = parity_r ^ (hit_vld && hit);
    out_valid_nxt  = 1'b0;
    out_inside_nxt = out_inside_r;
    out_tag_nxt    = out_tag_r;
    case (state_r)
      ert_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_op)
            ert_pkg::OP_CLEAR: begin
              count_nxt    = '0;
              max_x_nxt    = COORD_MIN;
              max_y_nxt    = COORD_MIN;
              next_tag_nxt = ert_pkg::TAG_FIRST;
            end
            ert_pkg::OP_APPEND: begin
              if (app_ok) begin
                count_nxt = count_r + CNT_W'(1);
                if ($signed(ax_w) > $signed(max_x_r)) begin
                  max_x_nxt = ax_w;
                end
                if ($signed(ay_w) > $signed(max_y_r)) begin
                  max_y_nxt = ay_w;
                end
              end
            end
            ert_pkg::OP_CLASSIFY: begin
              rd_idx_nxt = '0;
              parity_nxt = 1'b0;
              state_nxt  = (count_r == '0) ? ert_pkg::ST_DRAIN : ert_pkg::ST_RUN;
            end
            default: begin
            end
          endcase
        end
      end
      ert_pkg::ST_RUN: begin
        rv_nxt       = 1'b1;
        rv_first_nxt = (rd_idx_r == '0);
        rv_last_nxt  = rd_last;
        rd_idx_nxt   = rd_idx_r + IDX_W'(1);
        if (rd_last) begin
          state_nxt = ert_pkg::ST_DRAIN;
        end
      end
      ert_pkg::ST_DRAIN: begin
        if (pipe_empty) begin
          out_valid_nxt  = 1'b1;
          out_inside_nxt = parity_r;
          out_tag_nxt    = parity_r ? next_tag_r : ert_pkg::TAG_OUTSIDE;
          if (parity_r && (next_tag_r != ert_pkg::TAG_MAX)) begin
            next_tag_nxt = next_tag_r + ert_pkg::TAG_W'(1);
          end
          state_nxt = ert_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ert_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ert_pkg::ST_IDLE;
      count_r      <= '0;
      max_x_r      <= COORD_MIN;
      max_y_r      <= COORD_MIN;
      next_tag_r   <= ert_pkg::TAG_FIRST;
      rd_idx_r     <= '0;
      rv_r         <= 1'b0;
      rv_first_r   <= 1'b0;
      rv_last_r    <= 1'b0;
      close_pend_r <= 1'b0;
      parity_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      out_inside_r <= 1'b0;
      out_tag_r    <= ert_pkg::TAG_OUTSIDE;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      max_x_r      <= max_x_nxt;
      max_y_r      <= max_y_nxt;
      next_tag_r   <= next_tag_nxt;
      rd_idx_r     <= rd_idx_nxt;
      rv_r         <= rv_nxt;
      rv_first_r   <= rv_first_nxt;
      rv_last_r    <= rv_last_nxt;
      close_pend_r <= close_pend_nxt;
      parity_r     <= parity_nxt;
      out_valid_r  <= out_valid_nxt;
      out_inside_r <= out_inside_nxt;
      out_tag_r    <= out_tag_nxt;
    end
  end

  // hold centroid, ray vector and the vertices around the current edge
  always_ff @(posedge clk) begin
    if (accept && (in_op == ert_pkg::OP_CLASSIFY)) begin
      q_x_r <= sum_x[W+1:2];
      q_y_r <= sum_y[W+1:2];
    end
    s_x_r <= {{2{max_x_r[W-1]}}, max_x_r} + SW'(1) - {{2{q_x_r[W-1]}}, q_x_r};
    s_y_r <= {{2{max_y_r[W-1]}}, max_y_r} + SW'(1) - {{2{q_y_r[W-1]}}, q_y_r};
    if (rv_r) begin
      prev_x_r <= rd_x;
      prev_y_r <= rd_y;
    end
    if (rv_r && rv_first_r) begin
      first_x_r <= rd_x;
      first_y_r <= rd_y;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_r;
  assign out_tag        = out_tag_r;

endmodule

>>> rtl/core/ert_checker.sv
// Port-level checks on the element region tagger, bound to the top level.
// Depends on ert_pkg and element_region_tagger_defines.svh.
`timescale 1ns / 1ps
`include "element_region_tagger_defines.svh"

module ert_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic [1:0]                in_op,
  input logic                      out_valid,
  input logic                      out_inside_res,
  input logic [ert_pkg::TAG_W-1:0] out_tag
);

  `ERT_ASSERT_NXT(a_strobe_single, out_valid, !out_valid, "result strobe held two cycles")
  `ERT_ASSERT_IMP(a_idle_on_word, out_valid, !busy, "result word while still busy")
  `ERT_ASSERT_NXT(a_classify_busy, start && !busy && (in_op == ert_pkg::OP_CLASSIFY), busy, "classify did not raise busy")
  `ERT_ASSERT_IMP(a_outside_tag, out_valid && !out_inside_res, out_tag == ert_pkg::TAG_OUTSIDE, "outside word with wrong tag")
  `ERT_ASSERT_IMP(a_inside_tag, out_valid && out_inside_res, (out_tag != ert_pkg::TAG_OUTSIDE) && (out_tag != '0), "inside word with reserved tag")

endmodule

bind element_region_tagger ert_checker u_ert_checker (.*);

>>> dv/element_region_tagger_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for element_region_tagger: directed polygon cases, then random polygons
// and elements, each result checked against an in-bench crossing-count predictor.
// Depends on ert_pkg and the element_region_tagger RTL.

module element_region_tagger_tb;
  import ert_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int VERT_CAP   = 16;
  localparam int U          = 65536;
  localparam int IDLE_LIMIT = 2000;
  localparam int ITEMS      = 500;

  typedef logic signed [127:0] wide_t;

  typedef enum int {
    SPAN_GRID,
    SPAN_BOX,
    SPAN_FULL
  } span_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [FIELD_W-1:0] ax;
    logic [FIELD_W-1:0] ay;
    logic [FIELD_W-1:0] bx;
    logic [FIELD_W-1:0] by_coord;
    logic [FIELD_W-1:0] cx;
    logic [FIELD_W-1:0] cy;
    logic [FIELD_W-1:0] dx_coord;
    logic [FIELD_W-1:0] dy_coord;
  } word_t;

  typedef struct {
    logic             in_region;
    logic [TAG_W-1:0] tag;
  } tag_result_t;

  class tag_ledger;
    longint           vert_x[VERT_CAP];
    longint           vert_y[VERT_CAP];
    int unsigned      n_vert;
    longint           top_x;
    longint           top_y;
    logic [TAG_W-1:0] tag_next;
    tag_result_t      due[$];
    int               errors;
    int               n_results;
    int               n_inside;

    function new();
      clear_polygon();
      errors    = 0;
      n_results = 0;
      n_inside  = 0;
    endfunction

    function void clear_polygon();
      n_vert   = 0;
      top_x    = -(longint'(1) << (FIELD_W - 1));
      top_y    = top_x;
      tag_next = TAG_FIRST;
    endfunction

    function wide_t cross2d(wide_t ux, wide_t uy, wide_t vx, wide_t vy);
      return ux * vy - uy * vx;
    endfunction

    function bit open_between(wide_t num, wide_t den);
      if (den > 0) return num > 0 && num < den;
      return num < 0 && num > den;
    endfunction

    function bit edge_hit(longint px, longint py, longint p2x, longint p2y,
                          longint qx, longint qy, longint q2x, longint q2y);
      longint rx, ry, sx, sy, wx, wy;
      wide_t  rxs;
      rx  = p2x - px;
      ry  = p2y - py;
      sx  = q2x - qx;
      sy  = q2y - qy;
      wx  = qx - px;
      wy  = qy - py;
      rxs = cross2d(rx, ry, sx, sy);
      if (rxs == 0) return 1'b0;
      return open_between(cross2d(wx, wy, sx, sy), rxs) &&
             open_between(cross2d(wx, wy, rx, ry), rxs);
    endfunction

    function void take_word(word_t w);
      longint      mx, my, ex, ey;
      int unsigned hits, i, j;
      tag_result_t r;
      case (w.op)
        OP_CLEAR: begin
          clear_polygon();
        end
        OP_APPEND: begin
          if (n_vert < VERT_CAP) begin
            vert_x[n_vert] = $signed(w.ax);
            vert_y[n_vert] = $signed(w.ay);
            if (vert_x[n_vert] > top_x) top_x = vert_x[n_vert];
            if (vert_y[n_vert] > top_y) top_y = vert_y[n_vert];
            n_vert++;
          end
        end
        OP_CLASSIFY: begin
          mx = $signed(w.ax);
          mx += $signed(w.bx);
          mx += $signed(w.cx);
          mx += $signed(w.dx_coord);
          my = $signed(w.ay);
          my += $signed(w.by_coord);
          my += $signed(w.cy);
          my += $signed(w.dy_coord);
          mx = mx >>> 2;
          my = my >>> 2;
          ex = top_x + 1;
          ey = top_y + 1;
          hits = 0;
          for (i = 0; i < n_vert; i++) begin
            j = (i + 1 == n_vert) ? 0 : i + 1;
            if (edge_hit(vert_x[i], vert_y[i], vert_x[j], vert_y[j], mx, my, ex, ey)) hits++;
          end
          r.in_region = hits[0];
          if (hits[0]) begin
            r.tag = tag_next;
            if (tag_next != TAG_MAX) tag_next++;
            n_inside++;
          end else begin
            r.tag = TAG_OUTSIDE;
          end
          due.insert(due.size(), r);
        end
        default: begin
        end
      endcase
    endfunction

    function void match_result(logic in_region, logic [TAG_W-1:0] tag);
      tag_result_t r;
      n_results++;
      if (due.size() == 0) begin
        $display("%0t ns: result with nothing due: inside_res=%0b tag=%0d", $time, in_region,
                 tag);
        errors++;
        return;
      end
      r = due.pop_front();
      if (in_region !== r.in_region) begin
        $display("%0t ns: inside_res expected %0b actual %0b", $time, r.in_region, in_region);
        errors++;
      end
      if (tag !== r.tag) begin
        $display("%0t ns: tag expected %0d actual %0d", $time, r.tag, tag);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_op;
  logic [FIELD_W-1:0] in_ax;
  logic [FIELD_W-1:0] in_ay;
  logic [FIELD_W-1:0] in_bx;
  logic [FIELD_W-1:0] in_by_coord;
  logic [FIELD_W-1:0] in_cx;
  logic [FIELD_W-1:0] in_cy;
  logic [FIELD_W-1:0] in_dx_coord;
  logic [FIELD_W-1:0] in_dy_coord;
  logic               out_valid;
  logic               out_inside_res;
  logic [TAG_W-1:0]   out_tag;

  tag_ledger ledger;
  int        words_sent    = 0;
  int        classify_sent = 0;
  int        idle_cycles   = 0;
  int        random_base;
  bit        no_gaps       = 1'b0;

  element_region_tagger dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_op         (in_op),
    .in_ax         (in_ax),
    .in_ay         (in_ay),
    .in_bx         (in_bx),
    .in_by_coord   (in_by_coord),
    .in_cx         (in_cx),
    .in_cy         (in_cy),
    .in_dx_coord   (in_dx_coord),
    .in_dy_coord   (in_dy_coord),
    .out_valid     (out_valid),
    .out_inside_res(out_inside_res),
    .out_tag       (out_tag)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) ledger.match_result(out_inside_res, out_tag);
    if (!rst_n || out_valid || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t ns: no activity for %0d cycles, %0d results still due",
               $time, IDLE_LIMIT, ledger.due.size());
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic sender_gap();
    int n;
    if (no_gaps) return;
    n = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(3, 40);
    if (n == 0) return;
    @(negedge clk);
    start = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send_word(input word_t w);
    sender_gap();
    @(negedge clk);
    start       = 1'b1;
    in_op       = w.op;
    in_ax       = w.ax;
    in_ay       = w.ay;
    in_bx       = w.bx;
    in_by_coord = w.by_coord;
    in_cx       = w.cx;
    in_cy       = w.cy;
    in_dx_coord = w.dx_coord;
    in_dy_coord = w.dy_coord;
    do @(posedge clk); while (busy);
    ledger.take_word(w);
    if (w.op != OP_UNUSED) words_sent++;
    if (w.op == OP_CLASSIFY) classify_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start = 1'b0;
    while (ledger.due.size() != 0) @(posedge clk);
  endtask

  function automatic word_t random_word(logic [1:0] op);
    word_t w;
    w.op       = op;
    w.ax       = $urandom;
    w.ay       = $urandom;
    w.bx       = $urandom;
    w.by_coord = $urandom;
    w.cx       = $urandom;
    w.cy       = $urandom;
    w.dx_coord = $urandom;
    w.dy_coord = $urandom;
    return w;
  endfunction

  task automatic put_vertex(input logic [FIELD_W-1:0] x, input logic [FIELD_W-1:0] y);
    word_t w;
    w    = random_word(OP_APPEND);
    w.ax = x;
    w.ay = y;
    send_word(w);
  endtask

  task automatic classify4(input logic [FIELD_W-1:0] ax, ay, bx, by_c, cx, cy, dx, dy);
    word_t w;
    w.op       = OP_CLASSIFY;
    w.ax       = ax;
    w.ay       = ay;
    w.bx       = bx;
    w.by_coord = by_c;
    w.cx       = cx;
    w.cy       = cy;
    w.dx_coord = dx;
    w.dy_coord = dy;
    send_word(w);
  endtask

  task automatic classify_point(input logic [FIELD_W-1:0] x, input logic [FIELD_W-1:0] y);
    classify4(x, y, x, y, x, y, x, y);
  endtask

  function automatic logic [FIELD_W-1:0] pick_coord(span_t span);
    case (span)
      SPAN_GRID: return FIELD_W'((int'($urandom_range(0, 8)) - 4) * U);
      SPAN_BOX:  return FIELD_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
      default:   return $urandom;
    endcase
  endfunction

  function automatic logic [FIELD_W-1:0] near(logic [FIELD_W-1:0] t, span_t span);
    int reach;
    reach = (span == SPAN_GRID) ? 3 : 4096;
    if ($urandom_range(0, 1)) return t;
    return t + FIELD_W'(int'($urandom_range(0, 2 * reach)) - reach);
  endfunction

  task automatic polygon_run();
    span_t              span;
    logic [FIELD_W-1:0] tx, ty;
    span    = span_t'($urandom_range(0, 2));
    no_gaps = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 3) == 0) wait_drained();
    if ($urandom_range(0, 4) != 0) send_word(random_word(OP_CLEAR));
    repeat ($urandom_range(3, 18)) put_vertex(pick_coord(span), pick_coord(span));
    repeat ($urandom_range(1, 8)) begin
      if (span == SPAN_FULL) begin
        send_word(random_word(OP_CLASSIFY));
      end else begin
        tx = pick_coord(span);
        ty = pick_coord(span);
        if (span == SPAN_GRID && $urandom_range(0, 1)) begin
          tx += U / 2;
          ty += U / 2;
        end
        classify4(near(tx, span), near(ty, span), near(tx, span), near(ty, span),
                  near(tx, span), near(ty, span), near(tx, span), near(ty, span));
      end
    end
  endtask

  task automatic noise_run();
    no_gaps = 1'b0;
    repeat ($urandom_range(1, 6)) send_word(random_word(2'($urandom_range(0, 3))));
  endtask

  initial begin
    ledger      = new();
    rst_n       = 1'b0;
    start       = 1'b0;
    in_op       = OP_CLEAR;
    in_ax       = '0;
    in_ay       = '0;
    in_bx       = '0;
    in_by_coord = '0;
    in_cx       = '0;
    in_cy       = '0;
    in_dx_coord = '0;
    in_dy_coord = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty, single-vertex, then a square polygon of side 10 * U
    classify_point(0, 0);
    put_vertex(0, 0);
    classify_point(U, U);
    put_vertex(10 * U, 0);
    put_vertex(10 * U, 10 * U);
    put_vertex(0, 10 * U);
    classify_point(5 * U, 3 * U);
    classify4(U, U, 3 * U, U, 3 * U, 3 * U, U, 3 * U);
    classify_point(20 * U, 20 * U);
    classify_point(0, 5 * U);
    classify_point(10 * U, 10 * U);
    classify4(-1, -2, 0, -3, 0, 0, 0, 0);
    send_word(random_word(OP_UNUSED));
    classify4(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    classify4(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    // extreme triangle: interior and edge points must not wrap
    send_word(random_word(OP_CLEAR));
    put_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    put_vertex(32'h8000_0000, 32'h7FFF_FFFF);
    put_vertex(32'h8000_0000, 32'h8000_0000);
    classify_point(-(1 << 30), 0);
    classify_point(0, 0);
    wait_drained();

    random_base = words_sent;
    while (words_sent - random_base < ITEMS) begin
      if ($urandom_range(0, 9) < 8) polygon_run();
      else noise_run();
    end
    wait_drained();
    repeat (40) @(posedge clk);

    $display("Covered %0d words (%0d classify) on random and extreme polygons;",
             words_sent, classify_sent);
    $display("checked %0d results, %0d of them tagged inside.",
             ledger.n_results, ledger.n_inside);
    if (ledger.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/ert_pkg.sv
rtl/core/ert_ram.sv
rtl/core/ert_edge_pipe.sv
rtl/core/element_region_tagger.sv
rtl/core/ert_checker.sv
dv/element_region_tagger_tb.sv
